FILE: design/pcu_pkg.sv
// Shared types, codes and constants of the particle swarm update unit.
package pcu_pkg;

  localparam int FracBits     = 16;
  localparam int NumParticles = 64;
  localparam int NumDims      = 16;
  localparam int PartW        = 6;
  localparam int DimW         = 4;
  localparam int CellW        = PartW + DimW;
  localparam int CellCount    = NumParticles * NumDims;
  localparam int WordW        = 32;
  localparam int SqrtSteps    = 20;
  localparam int DivSteps     = 34;
  localparam int CntW         = 7;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 19;

  localparam logic [18:0] C1Reset    = 19'd134349;
  localparam logic [18:0] C2Reset    = 19'd134349;
  localparam logic [16:0] KReset     = 17'd65536;
  localparam logic [6:0]  CountReset = 7'd64;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_FIT    = 3'd1,
    ACT_SELECT = 3'd2,
    ACT_UPDATE = 3'd3,
    ACT_READ   = 3'd4
  } pcu_action_e;

  typedef enum logic [2:0] {
    CFG_C1    = 3'd0,
    CFG_C2    = 3'd1,
    CFG_K     = 3'd2,
    CFG_MIN   = 3'd3,
    CFG_RANGE = 3'd4,
    CFG_COUNT = 3'd5
  } pcu_cfg_e;

  typedef enum logic [1:0] {
    RNG_TWO  = 2'd0,
    RNG_ONE  = 2'd1,
    RNG_TEN  = 2'd2,
    RNG_FREE = 2'd3
  } pcu_range_e;

  typedef struct packed {
    logic            capture;
    logic            wr_elem;
    logic            wr_fit;
    logic            rd_cell;
    logic            rd_gbest;
    logic            scan_rd;
    logic            scan_cmp;
    logic [CntW-1:0] cnt;
    logic            mul_w;
    logic            calc_mag;
    logic            cap_cell;
    logic            cap_g;
    logic            calc_terms;
    logic            calc_inner;
    logic            sqrt_step;
    logic            den_calc;
    logic            div_step;
    logic            fac_calc;
    logic            mul_v;
    logic            nv_calc;
    logic            upd_write;
    logic            out_load;
  } pcu_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] scan_n;
  } pcu_status_t;

endpackage

FILE: design/pcu_ram.sv
// Generic single write port, single read port RAM with registered read.
module pcu_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pcu_datapath.sv
// Datapath: swarm stores, configuration, square root, divider and velocity math.
module pcu_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcu_pkg::pcu_cmd_t              cmd_i,
  output pcu_pkg::pcu_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [pcu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pcu_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [pcu_pkg::PartW-1:0]      particle_i,
  input  logic [pcu_pkg::DimW-1:0]       dimension_i,
  input  logic signed [31:0]             load_position_i,
  input  logic signed [31:0]             load_velocity_i,
  input  logic signed [31:0]             load_personal_best_i,
  input  logic signed [31:0]             load_fitness_i,
  input  logic [15:0]                    rand_one_i,
  input  logic [15:0]                    rand_two_i,
  output logic signed [31:0]             out_position_o,
  output logic signed [31:0]             out_velocity_o,
  output logic signed [31:0]             out_personal_best_o,
  output logic [pcu_pkg::PartW-1:0]      best_particle_o,
  output logic                           position_taken_o,
  output logic                           factor_saturated_o
);

  localparam logic signed [32:0] OneW  = 33'sd65536;
  localparam logic signed [31:0] SMax  = 32'sh7fffffff;
  localparam logic signed [31:0] SMin  = 32'sh80000000;

  // configuration
  logic [18:0] c1_q, c2_q;
  logic [16:0] k_q;
  logic        min_q;
  logic [1:0]  range_q;
  logic [6:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= pcu_pkg::C1Reset;
      c2_q    <= pcu_pkg::C2Reset;
      k_q     <= pcu_pkg::KReset;
      min_q   <= 1'b1;
      range_q <= pcu_pkg::RNG_TWO;
      count_q <= pcu_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (pcu_pkg::pcu_cfg_e'(cfg_index_i))
        pcu_pkg::CFG_C1:    c1_q    <= cfg_data_i[18:0];
        pcu_pkg::CFG_C2:    c2_q    <= cfg_data_i[18:0];
        pcu_pkg::CFG_K:     k_q     <= cfg_data_i[16:0];
        pcu_pkg::CFG_MIN:   min_q   <= cfg_data_i[0];
        pcu_pkg::CFG_RANGE: range_q <= cfg_data_i[1:0];
        pcu_pkg::CFG_COUNT: count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_q == '0) begin
      status_o.scan_n = 7'd1;
    end else if (count_q > 7'(pcu_pkg::NumParticles)) begin
      status_o.scan_n = 7'(pcu_pkg::NumParticles);
    end else begin
      status_o.scan_n = count_q;
    end
  end

  // captured item
  logic [pcu_pkg::PartW-1:0] part_q;
  logic [pcu_pkg::DimW-1:0]  dim_q;
  logic signed [31:0]        ld_pos_q, ld_vel_q, ld_pb_q, ld_fit_q;
  logic [15:0]               r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      part_q   <= particle_i;
      dim_q    <= dimension_i;
      ld_pos_q <= load_position_i;
      ld_vel_q <= load_velocity_i;
      ld_pb_q  <= load_personal_best_i;
      ld_fit_q <= load_fitness_i;
      r1_q     <= rand_one_i;
      r2_q     <= rand_two_i;
    end
  end

  logic [pcu_pkg::CellW-1:0] cell_addr, gcell;
  logic [pcu_pkg::PartW-1:0] best_q;
  assign cell_addr = {part_q, dim_q};
  assign gcell     = {best_q, dim_q};

  // stores
  logic                      pos_we, vel_we, pb_we;
  logic signed [31:0]        pos_wd, vel_wd;
  logic [31:0]               pos_rd, vel_rd, pb_rd, fit_rd;
  logic [pcu_pkg::CellW-1:0] pos_ra;
  logic signed [31:0]        nv_q;
  logic signed [32:0]        np;
  logic                      in_range;

  assign pos_we = cmd_i.wr_elem || (cmd_i.upd_write && in_range);
  assign vel_we = cmd_i.wr_elem || cmd_i.upd_write;
  assign pb_we  = cmd_i.wr_elem;
  assign pos_wd = cmd_i.wr_elem ? ld_pos_q : np[31:0];
  assign vel_wd = cmd_i.wr_elem ? ld_vel_q : nv_q;
  assign pos_ra = cmd_i.rd_gbest ? gcell : cell_addr;

  pcu_ram #(.Width(32), .Depth(pcu_pkg::CellCount)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(cell_addr), .wdata_i(pos_wd),
    .re_i(cmd_i.rd_cell || cmd_i.rd_gbest), .raddr_i(pos_ra), .rdata_o(pos_rd)
  );
  pcu_ram #(.Width(32), .Depth(pcu_pkg::CellCount)) u_vel_ram (
    .clk_i, .we_i(vel_we), .waddr_i(cell_addr), .wdata_i(vel_wd),
    .re_i(cmd_i.rd_cell), .raddr_i(cell_addr), .rdata_o(vel_rd)
  );
  pcu_ram #(.Width(32), .Depth(pcu_pkg::CellCount)) u_pb_ram (
    .clk_i, .we_i(pb_we), .waddr_i(cell_addr), .wdata_i(ld_pb_q),
    .re_i(cmd_i.rd_cell), .raddr_i(cell_addr), .rdata_o(pb_rd)
  );
  pcu_ram #(.Width(32), .Depth(pcu_pkg::NumParticles)) u_fit_ram (
    .clk_i, .we_i(cmd_i.wr_fit), .waddr_i(part_q), .wdata_i(ld_fit_q),
    .re_i(cmd_i.scan_rd), .raddr_i(cmd_i.cnt[pcu_pkg::PartW-1:0]), .rdata_o(fit_rd)
  );

  // best selection: compare the word read in the previous cycle
  logic signed [31:0]        bv_q;
  logic [pcu_pkg::PartW-1:0] scan_idx;
  logic                      better;
  assign scan_idx = pcu_pkg::PartW'(cmd_i.cnt - 7'd1);
  assign better   = min_q ? ($signed(fit_rd) < bv_q) : ($signed(fit_rd) > bv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (cmd_i.scan_cmp && (cmd_i.cnt == 7'd1 || better)) begin
      best_q <= scan_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_cmp && (cmd_i.cnt == 7'd1 || better)) begin
      bv_q <= $signed(fit_rd);
    end
  end

  // omega and the root operand
  logic [18:0]        w1_q, w2_q;
  logic [34:0]        p1, p2;
  logic [19:0]        w;
  logic signed [20:0] wm4;
  logic signed [41:0] wprod;
  logic [41:0]        wabs;
  logic [39:0]        mag_q;
  logic [19:0]        w_q;

  assign p1    = c1_q * r1_q;
  assign p2    = c2_q * r2_q;
  assign w     = {1'b0, w1_q} + {1'b0, w2_q};
  assign wm4   = $signed({1'b0, w}) - 21'sd262144;
  assign wprod = $signed({1'b0, w}) * wm4;
  assign wabs  = wprod[41] ? 42'(-wprod) : wprod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_w) begin
      w1_q <= p1[34:16];
      w2_q <= p2[34:16];
    end
    if (cmd_i.calc_mag) begin
      mag_q <= wabs[39:0];
      w_q   <= w;
    end
  end

  // element operands and the inner sum
  logic signed [31:0] x_q, v_q, pb_q, g_q;
  logic signed [32:0] d1, d2;
  logic signed [52:0] tp1, tp2;
  logic signed [36:0] t1_q, t2_q;
  logic signed [38:0] isum;
  logic signed [31:0] inner_q;

  assign d1   = {pb_q[31], pb_q} - {x_q[31], x_q};
  assign d2   = {g_q[31], g_q} - {x_q[31], x_q};
  assign tp1  = $signed({1'b0, w1_q}) * d1;
  assign tp2  = $signed({1'b0, w2_q}) * d2;
  assign isum = 39'(v_q) + 39'(t1_q) + 39'(t2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cell) begin
      x_q  <= $signed(pos_rd);
      v_q  <= $signed(vel_rd);
      pb_q <= $signed(pb_rd);
    end
    if (cmd_i.cap_g) begin
      g_q <= $signed(pos_rd);
    end
    if (cmd_i.calc_terms) begin
      t1_q <= tp1[52:16];
      t2_q <= tp2[52:16];
    end
    if (cmd_i.calc_inner) begin
      if (isum > 39'(SMax)) begin
        inner_q <= SMax;
      end else if (isum < 39'(SMin)) begin
        inner_q <= SMin;
      end else begin
        inner_q <= isum[31:0];
      end
    end
  end

  // square root, one result bit a cycle
  logic [39:0] sq_op_q;
  logic [20:0] sq_rem_q;
  logic [19:0] sq_root_q;
  logic [22:0] sq_rt, sq_trial;
  logic        sq_ge;

  assign sq_rt    = {sq_rem_q, sq_op_q[39:38]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = sq_rt >= sq_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_g) begin
      sq_op_q   <= mag_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_op_q   <= {sq_op_q[37:0], 2'b00};
      sq_rem_q  <= sq_ge ? 21'(sq_rt - sq_trial) : sq_rt[20:0];
      sq_root_q <= {sq_root_q[18:0], sq_ge};
    end
  end

  // denominator and divider, one quotient bit a cycle
  logic signed [22:0] den;
  logic               den_neg_q, den_zero_q;
  logic [20:0]        dv_q;
  logic [33:0]        dq_q;
  logic [21:0]        drem_q;
  logic [22:0]        drt;
  logic               dge;

  assign den = 23'sd131072 - $signed({3'b0, w_q}) - $signed({3'b0, sq_root_q});
  assign drt = {drem_q, dq_q[33]};
  assign dge = drt >= {2'b00, dv_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.den_calc) begin
      den_neg_q  <= den[22];
      den_zero_q <= den == '0;
      dv_q       <= den[22] ? 21'(-den) : den[20:0];
      dq_q       <= {k_q, 17'b0};
      drem_q     <= '0;
    end else if (cmd_i.div_step) begin
      drem_q <= dge ? 22'(drt - {2'b00, dv_q}) : drt[21:0];
      dq_q   <= {dq_q[32:0], dge};
    end
  end

  // factor, new velocity, new position
  logic signed [31:0] fac_q;
  logic signed [63:0] vprod_q;
  logic signed [47:0] vsh;
  logic               taken_q, sat_q;

  assign vsh = vprod_q[63:16];
  assign np  = {x_q[31], x_q} + {nv_q[31], nv_q};

  always_comb begin
    case (pcu_pkg::pcu_range_e'(range_q))
      pcu_pkg::RNG_TWO: in_range = !np[32] && np <= 33'(2 * OneW);
      pcu_pkg::RNG_ONE: in_range = !np[32] && np <= OneW;
      pcu_pkg::RNG_TEN: in_range = !np[32] && np <= 33'(10 * OneW);
      default:          in_range = np[32] == np[31];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fac_calc) begin
      if (den_zero_q) begin
        fac_q <= SMax;
      end else if (den_neg_q) begin
        fac_q <= (dq_q > 34'h080000000) ? SMin : 32'(-dq_q);
      end else begin
        fac_q <= (dq_q > 34'h07fffffff) ? SMax : dq_q[31:0];
      end
    end
    if (cmd_i.mul_v) begin
      vprod_q <= fac_q * inner_q;
    end
    if (cmd_i.nv_calc) begin
      if (vsh > 48'(SMax)) begin
        nv_q <= SMax;
      end else if (vsh < 48'(SMin)) begin
        nv_q <= SMin;
      end else begin
        nv_q <= vsh[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      sat_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      taken_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      if (cmd_i.fac_calc) begin
        sat_q <= den_zero_q || (den_neg_q ? dq_q > 34'h080000000 : dq_q > 34'h07fffffff);
      end
      if (cmd_i.upd_write) begin
        taken_q <= in_range;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_position_o      <= $signed(pos_rd);
      out_velocity_o      <= $signed(vel_rd);
      out_personal_best_o <= $signed(pb_rd);
      best_particle_o     <= best_q;
      position_taken_o    <= taken_q;
      factor_saturated_o  <= sat_q;
    end
  end

endmodule

FILE: design/pcu_ctrl.sv
// Controller: sequences each action and drives the handshakes.
module pcu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           action_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  pcu_pkg::pcu_status_t status_i,
  output pcu_pkg::pcu_cmd_t    cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_LOADW = 18'h00002,
    ST_FITW  = 18'h00004,
    ST_SCAN  = 18'h00008,
    ST_URD   = 18'h00010,
    ST_UW    = 18'h00020,
    ST_UG    = 18'h00040,
    ST_UT    = 18'h00080,
    ST_UI    = 18'h00100,
    ST_USQ   = 18'h00200,
    ST_UDEN  = 18'h00400,
    ST_UDIV  = 18'h00800,
    ST_UFAC  = 18'h01000,
    ST_UMV   = 18'h02000,
    ST_UNV   = 18'h04000,
    ST_UWR   = 18'h08000,
    ST_RD    = 18'h10000,
    ST_FIN   = 18'h20000
  } pcu_state_e;

  pcu_state_e                 state_q, state_d;
  logic [pcu_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.cnt   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d = '0;
          case (pcu_pkg::pcu_action_e'(action_i))
            pcu_pkg::ACT_LOAD:   state_d = ST_LOADW;
            pcu_pkg::ACT_FIT:    state_d = ST_FITW;
            pcu_pkg::ACT_SELECT: state_d = ST_SCAN;
            pcu_pkg::ACT_UPDATE: state_d = ST_URD;
            default:             state_d = ST_RD;
          endcase
        end
      end
      ST_LOADW: begin
        cmd_o.wr_elem = 1'b1;
        state_d = ST_RD;
      end
      ST_FITW: begin
        cmd_o.wr_fit = 1'b1;
        state_d = ST_RD;
      end
      ST_SCAN: begin
        // read word cnt, compare word cnt-1
        cmd_o.scan_rd  = cnt_q < status_i.scan_n;
        cmd_o.scan_cmp = cnt_q != '0;
        if (cnt_q == status_i.scan_n) begin
          state_d = ST_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_URD: begin
        cmd_o.mul_w   = 1'b1;
        cmd_o.rd_cell = 1'b1;
        state_d = ST_UW;
      end
      ST_UW: begin
        cmd_o.calc_mag = 1'b1;
        cmd_o.cap_cell = 1'b1;
        cmd_o.rd_gbest = 1'b1;
        state_d = ST_UG;
      end
      ST_UG: begin
        cmd_o.cap_g = 1'b1;
        state_d = ST_UT;
      end
      ST_UT: begin
        cmd_o.calc_terms = 1'b1;
        state_d = ST_UI;
      end
      ST_UI: begin
        cmd_o.calc_inner = 1'b1;
        cnt_d = '0;
        state_d = ST_USQ;
      end
      ST_USQ: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == pcu_pkg::CntW'(pcu_pkg::SqrtSteps - 1)) begin
          state_d = ST_UDEN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_UDEN: begin
        cmd_o.den_calc = 1'b1;
        cnt_d = '0;
        state_d = ST_UDIV;
      end
      ST_UDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == pcu_pkg::CntW'(pcu_pkg::DivSteps - 1)) begin
          state_d = ST_UFAC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_UFAC: begin
        cmd_o.fac_calc = 1'b1;
        state_d = ST_UMV;
      end
      ST_UMV: begin
        cmd_o.mul_v = 1'b1;
        state_d = ST_UNV;
      end
      ST_UNV: begin
        cmd_o.nv_calc = 1'b1;
        state_d = ST_UWR;
      end
      ST_UWR: begin
        cmd_o.upd_write = 1'b1;
        state_d = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd_cell = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold the read data until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted word did not start work");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cnt_q <= status_i.scan_n)
    else $error("scan ran past particle count");

  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_USQ |-> cnt_q < pcu_pkg::CntW'(pcu_pkg::SqrtSteps))
    else $error("root iteration count overflow");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UDIV |-> cnt_q < pcu_pkg::CntW'(pcu_pkg::DivSteps))
    else $error("divide iteration count overflow");

endmodule

FILE: design/pso_constriction_update_unit.sv
// Select best scans n fitness words where n is particle_count clipped to
// 1..64; in an update the bit-serial square root and divide dominate.
// Throughput: one word at a time; the next word is taken once the current
// one reaches the output register, which may still wait to be taken.
// Reset clears control, configuration to defaults and best index to zero;
// the swarm stores are undefined until written.
module pso_constriction_update_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   action_i,
  input  logic [5:0]                   particle_i,
  input  logic [3:0]                   dimension_i,
  input  logic signed [31:0]           load_position_i,
  input  logic signed [31:0]           load_velocity_i,
  input  logic signed [31:0]           load_personal_best_i,
  input  logic signed [31:0]           load_fitness_i,
  input  logic [15:0]                  rand_one_i,
  input  logic [15:0]                  rand_two_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           out_position_o,
  output logic signed [31:0]           out_velocity_o,
  output logic signed [31:0]           out_personal_best_o,
  output logic [5:0]                   best_particle_o,
  output logic                         position_taken_o,
  output logic                         factor_saturated_o
);

  pcu_pkg::pcu_cmd_t    cmd;
  pcu_pkg::pcu_status_t status;

  pcu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .out_valid_o, .out_stall_i, .status_i(status), .cmd_o(cmd)
  );

  pcu_datapath u_datapath (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .particle_i, .dimension_i, .load_position_i, .load_velocity_i,
    .load_personal_best_i, .load_fitness_i, .rand_one_i, .rand_two_i,
    .out_position_o, .out_velocity_o, .out_personal_best_o,
    .best_particle_o, .position_taken_o, .factor_saturated_o
  );

endmodule
